FILE: rtl/mbwm_pkg.sv
// Shared types, register indexes and width helpers for the wheel mixer.
package mbwm_pkg;

	// Chassis modes as held in the mode register
	typedef enum logic [1:0] {
		MODE_MECANUM    = 2'd0,
		MODE_FOUR_WHEEL = 2'd1,
		MODE_ACKERMANN  = 2'd2,
		MODE_TANK       = 2'd3
	} mbwm_mode_t;

	// Configuration register indexes
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;

	localparam logic [CFG_INDEX_W-1:0] REG_CHASSIS_MODE      = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_WHEEL_SPACING     = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_AXLE_SPACING      = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SPEED_LIMIT       = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_DUTY_GAIN         = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_DUTY_LIMIT        = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_VOLTAGE_THRESHOLD = 3'd6;

	// Field widths
	localparam int VEL_W     = 16;
	localparam int SPACING_W = 12;
	localparam int ARM_W     = SPACING_W + 1;
	localparam int SPEED_W   = 15;
	localparam int GAIN_W    = 16;
	localparam int DUTY_W    = 15;
	localparam int VOLT_W    = 16;
	// yaw (16 signed) times arm length (13 unsigned)
	localparam int YAW_PROD_W = VEL_W + ARM_W + 1;

	// Stage control handed to each wheel lane
	typedef struct packed {
		logic load_s3;
		logic load_s4;
	} mbwm_adv_t;

	// Width of twice the wheel target in Q(2*frac)
	function automatic int mbwm_target_w(input int frac);
		int lin_w;
		lin_w = frac + VEL_W + 2;
		return ((lin_w > YAW_PROD_W + 1) ? lin_w : YAW_PROD_W + 1) + 1;
	endfunction

	// Width of a clamped target magnitude
	function automatic int mbwm_mag_w(input int frac);
		return frac + SPEED_W + 1;
	endfunction

	// Width of magnitude times duty gain
	function automatic int mbwm_prod_w(input int frac);
		return mbwm_mag_w(frac) + GAIN_W;
	endfunction

endpackage

FILE: rtl/mbwm_wheel_lane.sv
// One wheel lane: clamp the target to the speed limit, then scale it by the duty gain.
module mbwm_wheel_lane import mbwm_pkg::*; #(
	parameter int FRAC_BITS = 10
) (
	input  logic                                      clk,
	input  mbwm_adv_t                                 adv,
	input  logic signed [mbwm_target_w(FRAC_BITS)-1:0] target,
	input  logic [SPEED_W-1:0]                        speed_limit,
	input  logic [GAIN_W-1:0]                         duty_gain,
	output logic [mbwm_prod_w(FRAC_BITS)-1:0]         product,
	output logic                                      negative
);

	localparam int TW  = mbwm_target_w(FRAC_BITS);
	localparam int MW  = mbwm_mag_w(FRAC_BITS);
	localparam int PRW = mbwm_prod_w(FRAC_BITS);

	logic [MW-1:0]  lim;
	logic [TW-1:0]  abs_c;
	logic [MW-1:0]  mag_c;
	logic [MW-1:0]  mag_s3;
	logic           neg_s3;
	logic [PRW-1:0] product_s4;
	logic           neg_s4;

	// Clamp the magnitude to the speed limit scaled to the target format
	always_comb begin
		lim   = MW'(speed_limit) << (FRAC_BITS + 1);
		abs_c = target[TW-1] ? TW'(-target) : TW'(target);
		mag_c = (abs_c > TW'(lim)) ? lim : abs_c[MW-1:0];
	end

	always_ff @(posedge clk) begin
		if (adv.load_s3) begin
			mag_s3 <= mag_c;
			neg_s3 <= target[TW-1];
		end
	end

	// Scale by the duty gain
	always_ff @(posedge clk) begin
		if (adv.load_s4) begin
			product_s4 <= PRW'(mag_s3) * PRW'(duty_gain);
			neg_s4     <= neg_s3;
		end
	end

	assign product  = product_s4;
	assign negative = neg_s4;

endmodule

FILE: rtl/mobile_base_wheel_mixer.sv
// Top level of the mobile base wheel mixer.
// Turns one body velocity command per transaction into forward and reverse duties for four
// motors, by mecanum, four-wheel, tank or Ackermann kinematics chosen by chassis_mode.
// The block is a five-stage pipeline of yaw multiply, wheel sum, speed clamp, gain multiply
// and duty clamp; it accepts a transaction in every cycle while the output is not stalled. A
// stalled output holds the pipeline stages behind it and empty stages still fill. Write
// configuration registers only while the pipeline is empty.
module mobile_base_wheel_mixer import mbwm_pkg::*; #(
	parameter int FRAC_BITS = 10
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// configuration
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_data,
	// input channel
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [VEL_W-1:0]   vel_x,
	input  logic signed [VEL_W-1:0]   vel_y,
	input  logic signed [VEL_W-1:0]   yaw_rate,
	input  logic                      manual_wheels,
	input  logic signed [VEL_W-1:0]   left_speed,
	input  logic signed [VEL_W-1:0]   right_speed,
	input  logic [VOLT_W-1:0]         battery_centivolts,
	// output channel
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [DUTY_W-1:0]         motor_a_forward,
	output logic [DUTY_W-1:0]         motor_a_reverse,
	output logic [DUTY_W-1:0]         motor_b_forward,
	output logic [DUTY_W-1:0]         motor_b_reverse,
	output logic [DUTY_W-1:0]         motor_c_forward,
	output logic [DUTY_W-1:0]         motor_c_reverse,
	output logic [DUTY_W-1:0]         motor_d_forward,
	output logic [DUTY_W-1:0]         motor_d_reverse,
	output logic                      outputs_enabled
);

	localparam int TW  = mbwm_target_w(FRAC_BITS);
	localparam int PRW = mbwm_prod_w(FRAC_BITS);
	localparam int NUM_WHEELS = 4;

	// Configuration registers
	mbwm_mode_t          mode_q;
	logic [SPACING_W-1:0] wheel_spacing_q;
	logic [SPACING_W-1:0] axle_spacing_q;
	logic [SPEED_W-1:0]   speed_limit_q;
	logic [GAIN_W-1:0]    duty_gain_q;
	logic [DUTY_W-1:0]    duty_limit_q;
	logic [VOLT_W-1:0]    voltage_threshold_q;

	// Pipeline control
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic load_s1, load_s2, load_s3, load_s4, load_s5;
	mbwm_adv_t adv;

	// Stage 1
	logic [ARM_W-1:0]            arm_len;
	logic signed [YAW_PROD_W-1:0] yaw_prod_c;
	logic signed [YAW_PROD_W-1:0] yaw_prod_s1;
	logic signed [VEL_W-1:0]     vx_s1, vy_s1, left_s1, right_s1;
	logic                        manual_s1, low_s1;

	// Stage 2
	logic signed [TW-1:0] rot_c, vxe, vye, lefte, righte;
	logic signed [TW-1:0] tgt_c  [NUM_WHEELS];
	logic signed [TW-1:0] tgt_s2 [NUM_WHEELS];
	logic                 low_s2;

	// Stages 3 and 4
	logic                 low_s3, low_s4;
	logic [PRW-1:0]       lane_prod [NUM_WHEELS];
	logic                 lane_neg  [NUM_WHEELS];

	// Stage 5
	logic [DUTY_W-1:0]    fwd_c [NUM_WHEELS];
	logic [DUTY_W-1:0]    rev_c [NUM_WHEELS];
	logic [DUTY_W-1:0]    fwd_s5 [NUM_WHEELS];
	logic [DUTY_W-1:0]    rev_s5 [NUM_WHEELS];
	logic                 en_s5;

	// Decode configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q              <= MODE_MECANUM;
			wheel_spacing_q     <= SPACING_W'(512);
			axle_spacing_q      <= SPACING_W'(512);
			speed_limit_q       <= SPEED_W'(10240);
			duty_gain_q         <= GAIN_W'(50000);
			duty_limit_q        <= DUTY_W'(16700);
			voltage_threshold_q <= VOLT_W'(1100);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CHASSIS_MODE:      mode_q              <= mbwm_mode_t'(cfg_data[1:0]);
				REG_WHEEL_SPACING:     wheel_spacing_q     <= cfg_data[SPACING_W-1:0];
				REG_AXLE_SPACING:      axle_spacing_q      <= cfg_data[SPACING_W-1:0];
				REG_SPEED_LIMIT:       speed_limit_q       <= cfg_data[SPEED_W-1:0];
				REG_DUTY_GAIN:         duty_gain_q         <= cfg_data[GAIN_W-1:0];
				REG_DUTY_LIMIT:        duty_limit_q        <= cfg_data[DUTY_W-1:0];
				REG_VOLTAGE_THRESHOLD: voltage_threshold_q <= cfg_data[VOLT_W-1:0];
				default: ;
			endcase
		end
	end

	// Advance each stage when it is empty or the one after it moves
	assign load_s5  = !valid_s5 || out_ready;
	assign load_s4  = !valid_s4 || load_s5;
	assign load_s3  = !valid_s3 || load_s4;
	assign load_s2  = !valid_s2 || load_s3;
	assign load_s1  = !valid_s1 || load_s2;
	assign in_ready = load_s1;
	assign adv      = '{load_s3: load_s3, load_s4: load_s4};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (load_s1) valid_s1 <= in_valid;
			if (load_s2) valid_s2 <= valid_s1;
			if (load_s3) valid_s3 <= valid_s2;
			if (load_s4) valid_s4 <= valid_s3;
			if (load_s5) valid_s5 <= valid_s4;
		end
	end

	// Stage 1: yaw times arm length, battery check
	always_comb begin
		case (mode_q) inside
			MODE_MECANUM, MODE_FOUR_WHEEL:
				arm_len = ARM_W'(axle_spacing_q) + ARM_W'(wheel_spacing_q);
			default:
				arm_len = ARM_W'(wheel_spacing_q);
		endcase
		yaw_prod_c = yaw_rate * $signed({1'b0, arm_len});
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			yaw_prod_s1 <= yaw_prod_c;
			vx_s1       <= vel_x;
			vy_s1       <= vel_y;
			left_s1     <= left_speed;
			right_s1    <= right_speed;
			manual_s1   <= manual_wheels;
			low_s1      <= battery_centivolts < voltage_threshold_q;
		end
	end

	// Stage 2: form twice each wheel target in Q(2*FRAC_BITS)
	always_comb begin
		vxe    = TW'(vx_s1) <<< (FRAC_BITS + 1);
		vye    = TW'(vy_s1) <<< (FRAC_BITS + 1);
		lefte  = TW'(left_s1) <<< (FRAC_BITS + 1);
		righte = TW'(right_s1) <<< (FRAC_BITS + 1);
		// half-track term in Ackermann, full term elsewhere
		rot_c  = (mode_q == MODE_ACKERMANN) ? TW'(yaw_prod_s1) : (TW'(yaw_prod_s1) <<< 1);
		case (mode_q) inside
			MODE_MECANUM, MODE_FOUR_WHEEL: begin
				tgt_c[0] = vxe + vye - rot_c;
				tgt_c[1] = vye - vxe - rot_c;
				tgt_c[2] = vye - vxe + rot_c;
				tgt_c[3] = vxe + vye + rot_c;
			end
			MODE_TANK: begin
				tgt_c[0] = rot_c - vxe;
				tgt_c[1] = vxe + rot_c;
				tgt_c[2] = '0;
				tgt_c[3] = '0;
			end
			default: begin
				tgt_c[0] = manual_s1 ? righte : (vxe + rot_c);
				tgt_c[1] = manual_s1 ? lefte : (vxe - rot_c);
				tgt_c[2] = '0;
				tgt_c[3] = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			tgt_s2 <= tgt_c;
			low_s2 <= low_s1;
		end
	end

	// Stages 3 and 4: speed clamp and gain, one lane per wheel
	for (genvar i = 0; i < NUM_WHEELS; i++) begin : g_lane
		mbwm_wheel_lane #(
			.FRAC_BITS (FRAC_BITS)
		) u_lane (
			.clk         (clk),
			.adv         (adv),
			.target      (tgt_s2[i]),
			.speed_limit (speed_limit_q),
			.duty_gain   (duty_gain_q),
			.product     (lane_prod[i]),
			.negative    (lane_neg[i])
		);
	end

	always_ff @(posedge clk) begin
		if (load_s3) low_s3 <= low_s2;
		if (load_s4) low_s4 <= low_s3;
	end

	// Stage 5: drop fraction bits, clamp to duty limit, apply polarity and split
	for (genvar i = 0; i < NUM_WHEELS; i++) begin : g_duty
		localparam logic FLIP_LANE = (i == 1) || (i == 2);
		logic [PRW-1:0]    shifted;
		logic [DUTY_W-1:0] mag;
		logic              neg;

		always_comb begin
			shifted = lane_prod[i] >> (2 * FRAC_BITS + 1);
			mag     = (shifted > PRW'(duty_limit_q)) ? duty_limit_q : shifted[DUTY_W-1:0];
			neg     = lane_neg[i] ^ (FLIP_LANE &&
				(mode_q == MODE_MECANUM || mode_q == MODE_FOUR_WHEEL));
			fwd_c[i] = (low_s4 || neg)  ? '0 : mag;
			rev_c[i] = (low_s4 || !neg) ? '0 : mag;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s5) begin
			fwd_s5 <= fwd_c;
			rev_s5 <= rev_c;
			en_s5  <= !low_s4;
		end
	end

	assign out_valid       = valid_s5;
	assign motor_a_forward = fwd_s5[0];
	assign motor_a_reverse = rev_s5[0];
	assign motor_b_forward = fwd_s5[1];
	assign motor_b_reverse = rev_s5[1];
	assign motor_c_forward = fwd_s5[2];
	assign motor_c_reverse = rev_s5[2];
	assign motor_d_forward = fwd_s5[3];
	assign motor_d_reverse = rev_s5[3];
	assign outputs_enabled = en_s5;

endmodule

FILE: rtl/mbwm_checker.sv
// Port-level checks on the wheel mixer, bound to the top level.
module mbwm_checker import mbwm_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic [DUTY_W-1:0]       motor_a_forward,
	input logic [DUTY_W-1:0]       motor_a_reverse,
	input logic [DUTY_W-1:0]       motor_b_forward,
	input logic [DUTY_W-1:0]       motor_b_reverse,
	input logic [DUTY_W-1:0]       motor_c_forward,
	input logic [DUTY_W-1:0]       motor_c_reverse,
	input logic [DUTY_W-1:0]       motor_d_forward,
	input logic [DUTY_W-1:0]       motor_d_reverse,
	input logic                    outputs_enabled
);

	// Low battery forces every duty to zero
	a_low_battery_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !outputs_enabled) |->
		(motor_a_forward == '0 && motor_a_reverse == '0 &&
		 motor_b_forward == '0 && motor_b_reverse == '0 &&
		 motor_c_forward == '0 && motor_c_reverse == '0 &&
		 motor_d_forward == '0 && motor_d_reverse == '0))
		else $error("duty driven while outputs disabled");

	// A motor never drives forward and reverse at once
	a_one_direction: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |->
		((motor_a_forward == '0 || motor_a_reverse == '0) &&
		 (motor_b_forward == '0 || motor_b_reverse == '0) &&
		 (motor_c_forward == '0 || motor_c_reverse == '0) &&
		 (motor_d_forward == '0 || motor_d_reverse == '0)))
		else $error("motor driven in both directions");

	// Hold a stalled result: valid, motor A and B forward duties and the enable stay stable
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(motor_a_forward) &&
		 $stable(motor_b_forward) && $stable(outputs_enabled)))
		else $error("stalled result changed");

	// No result can appear straight out of reset
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("result shown right after reset");

endmodule

bind mobile_base_wheel_mixer mbwm_checker u_mbwm_checker (.*);
